// ===== hdl/scan_priority_queue_core_defines.svh =====
// assertion macros for the scan priority queue
`ifndef SCAN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SCAN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq check failed");
// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq check failed");
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons)
`define SPQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/spq_pkg.sv =====
package spq_pkg;

   // default queue depth
   localparam int SPQ_CAPACITY = 16;

   // fixed field widths
   localparam int SPQ_VALUE_W = 32;
   localparam int SPQ_MODE_W  = 2;
   localparam int SPQ_STAT_W  = 2;
   localparam int SPQ_OCC_W   = 11;

   // operation codes
   localparam logic [SPQ_MODE_W-1:0] OP_PUSH = 2'd0;
   localparam logic [SPQ_MODE_W-1:0] OP_POP  = 2'd1;
   localparam logic [SPQ_MODE_W-1:0] OP_PEEK = 2'd2;

   // status codes
   localparam logic [SPQ_STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [SPQ_STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [SPQ_STAT_W-1:0] ST_EMPTY = 2'd2;

   // controls broadcast to every cell
   typedef struct packed {
      logic push_en;
      logic shift_en;
      logic min_mode;
   } spq_ctrl_type;

   // running best candidate handed along the chain
   typedef struct packed {
      logic                          live;
      logic signed [SPQ_VALUE_W-1:0] value;
   } spq_cand_type;

   // strict win of a candidate over the current best
   function automatic logic spq_beats(input logic signed [SPQ_VALUE_W-1:0] cand,
                                      input logic signed [SPQ_VALUE_W-1:0] best,
                                      input logic min_mode);
      logic res;
      if (min_mode) begin
         res = cand < best;
      end else begin
         res = cand > best;
      end
      return res;
   endfunction

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY,
   parameter int INDEX    = 0,
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spq_ctrl_type                  ctrl,
   input  logic [IDX_W-1:0]              push_idx,
   input  logic [IDX_W-1:0]              remove_idx,
   input  logic signed [SPQ_VALUE_W-1:0] push_value,
   input  logic signed [SPQ_VALUE_W-1:0] next_value,
   input  logic                          next_occ,
   output logic signed [SPQ_VALUE_W-1:0] value,
   output logic                          occ,
   input  spq_cand_type                  cand_in,
   input  logic [IDX_W-1:0]              cand_idx_in,
   output spq_cand_type                  cand_out,
   output logic [IDX_W-1:0]              cand_idx_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [SPQ_VALUE_W-1:0] value_ff;
   logic                          occ_ff;
   spq_cand_type                  cand_ff;
   spq_cand_type                  cand_next_in;
   logic [IDX_W-1:0]              cand_idx_ff;
   logic [IDX_W-1:0]              cand_idx_next_in;
   logic                          own_wins;
   logic                          load_push;
   logic                          load_shift;

   // slot writes: append at the fill point, close the gap on removal
   assign load_push  = ctrl.push_en && (push_idx == MY_IDX);
   assign load_shift = ctrl.shift_en && (MY_IDX >= remove_idx);

   // this slot, if occupied, takes over as best when no live candidate arrives or on a strict win
   assign own_wins = occ_ff && (!cand_in.live || spq_beats(value_ff, cand_in.value,
                                                           ctrl.min_mode));

   always_comb begin
      if (own_wins) begin
         cand_next_in.live  = 1'b1;
         cand_next_in.value = value_ff;
         cand_idx_next_in   = MY_IDX;
      end else begin
         cand_next_in       = cand_in;
         cand_idx_next_in   = cand_idx_in;
      end
   end

   // occupancy and candidate hand-on
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= 1'b0;
         cand_ff.live <= 1'b0;
      end else begin
         if (load_push) begin
            occ_ff <= 1'b1;
         end else if (load_shift) begin
            occ_ff <= next_occ;
         end
         cand_ff.live <= cand_next_in.live;
      end
      cand_ff.value <= cand_next_in.value;
      cand_idx_ff   <= cand_idx_next_in;
   end

   // stored value
   always_ff @(posedge clock) begin
      if (load_push) begin
         value_ff <= push_value;
      end else if (load_shift) begin
         value_ff <= next_value;
      end
   end

   assign value        = value_ff;
   assign occ          = occ_ff;
   assign cand_out     = cand_ff;
   assign cand_idx_out = cand_idx_ff;

endmodule

// ===== hdl/scan_priority_queue_core.sv =====
// scan priority queue: row of CAPACITY cells in arrival order
// push, refused push, empty pop/peek, unused codes: result the next cycle, one per cycle
// pop and peek: result set by the best-so-far candidate walking one cell per cycle down
//   the row; busy high meanwhile, so no new request is taken until the result
// results are single-cycle strobes and cannot be stalled
// synchronous reset empties the queue and selects max-first order
`include "scan_priority_queue_core_defines.svh"
module scan_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [SPQ_MODE_W-1:0]         req_mode,
   input  logic signed [SPQ_VALUE_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic signed [SPQ_VALUE_W-1:0] rsp_result_value,
   output logic [SPQ_STAT_W-1:0]         rsp_status,
   output logic [SPQ_OCC_W-1:0]          rsp_occupancy,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type                     state_ff;
   logic [IDX_W-1:0]              step_ff;
   logic [CNT_W-1:0]              count_ff;
   logic                          order_mode_ff;
   logic                          pop_ff;
   logic                          rsp_strobe_ff;
   logic signed [SPQ_VALUE_W-1:0] rsp_value_ff;
   logic [SPQ_STAT_W-1:0]         rsp_status_ff;
   logic [CNT_W-1:0]              rsp_count_ff;

   logic                          accept;
   logic                          scan_done;
   spq_ctrl_type                  ctrl;
   logic [IDX_W-1:0]              remove_idx;

   logic signed [SPQ_VALUE_W-1:0] value_w [CAPACITY];
   logic                          occ_w   [CAPACITY];
   spq_cand_type                  cand_w  [CAPACITY];
   logic [IDX_W-1:0]              cidx_w  [CAPACITY];

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign scan_done = (state_ff == S_SCAN) && (step_ff == LAST_IDX);

   // cell controls
   assign remove_idx    = cidx_w[CAPACITY-1];
   assign ctrl.push_en  = accept && (req_mode == OP_PUSH) && (count_ff != FULL_CNT);
   assign ctrl.shift_en = scan_done && pop_ff;
   assign ctrl.min_mode = order_mode_ff;

   // row of cells
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      spq_cand_type                  cin;
      logic [IDX_W-1:0]              cidx_in;
      logic signed [SPQ_VALUE_W-1:0] nval;
      logic                          nocc;

      if (k == 0) begin : g_first
         assign cin.live  = 1'b0;
         assign cin.value = '0;
         assign cidx_in   = '0;
      end else begin : g_rest
         assign cin     = cand_w[k-1];
         assign cidx_in = cidx_w[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign nval = '0;
         assign nocc = 1'b0;
      end else begin : g_mid
         assign nval = value_w[k+1];
         assign nocc = occ_w[k+1];
      end

      spq_cell #(
         .CAPACITY(CAPACITY),
         .INDEX   (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_idx    (count_ff[IDX_W-1:0]),
         .remove_idx  (remove_idx),
         .push_value  (req_value),
         .next_value  (nval),
         .next_occ    (nocc),
         .value       (value_w[k]),
         .occ         (occ_w[k]),
         .cand_in     (cin),
         .cand_idx_in (cidx_in),
         .cand_out    (cand_w[k]),
         .cand_idx_out(cidx_w[k])
      );
   end

   // sequencer with registered result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         count_ff      <= '0;
         order_mode_ff <= 1'b0;
         pop_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_status_ff <= ST_DONE;
         rsp_count_ff  <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            order_mode_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= ST_DONE;
                  rsp_count_ff  <= count_ff;
                  step_ff       <= '0;
                  pop_ff        <= (req_mode == OP_POP);
                  case (req_mode)
                     OP_PUSH: begin
                        rsp_strobe_ff <= 1'b1;
                        if (count_ff == FULL_CNT) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           count_ff     <= count_ff + 1'b1;
                           rsp_count_ff <= count_ff + 1'b1;
                        end
                     end
                     OP_POP, OP_PEEK: begin
                        if (count_ff == '0) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= ST_EMPTY;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               step_ff <= step_ff + 1'b1;
               if (scan_done) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_value_ff  <= cand_w[CAPACITY-1].value;
                  if (pop_ff) begin
                     count_ff     <= count_ff - 1'b1;
                     rsp_count_ff <= count_ff - 1'b1;
                  end else begin
                     rsp_count_ff <= count_ff;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = SPQ_OCC_W'(rsp_count_ff);

   // checks
   `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= FULL_CNT)
   `SPQ_ASSERT_NXT(a_scan_answers, scan_done, rsp_strobe && !busy)
   `SPQ_ASSERT_IMP(a_scan_found, scan_done, cand_w[CAPACITY-1].live)
   `SPQ_ASSERT_IMP(a_empty_occ, rsp_strobe && (rsp_status == ST_EMPTY), rsp_occupancy == '0)

endmodule
